[rtl/stun_message_validator_defines.svh]
// ----------------------------------------------------------------------------
// STUN message validator assertion macros
// Shared property forms for the checker of the validator's ports.
// ----------------------------------------------------------------------------
`ifndef STUN_MESSAGE_VALIDATOR_DEFINES_SVH
`define STUN_MESSAGE_VALIDATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STUNMV_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STUNMV_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/stunmv_pkg.sv]
// ----------------------------------------------------------------------------
// STUN message validator package
// Item types, status codes, walk phases and sizing constants.
// ----------------------------------------------------------------------------
package stunmv_pkg;

	// Header is 20 bytes; byte position saturates at the top of 17 bits.
	localparam int HDR_BYTES     = 20;
	localparam int POS_W         = 17;
	localparam int ATTR_TYPE_MAX = 11;

	// Attribute limit per datagram and the counter width it needs.
	localparam int MAX_ATTRS  = 16;
	localparam int ATTR_CNT_W = $clog2(MAX_ATTRS + 1);

	// Result status codes.
	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_SHORT         = 3'd1,
		ST_UNKNOWN_TYPE  = 3'd2,
		ST_LEN_MISMATCH  = 3'd3,
		ST_ATTR_OVERRUN  = 3'd4,
		ST_BAD_ATTR_TYPE = 3'd5,
		ST_TOO_MANY      = 3'd6
	} status_t;

	// Position inside a 4-byte attribute header.
	typedef enum logic [1:0] {
		PH_TYPE_HI = 2'd0,
		PH_TYPE_LO = 2'd1,
		PH_LEN_HI  = 2'd2,
		PH_LEN_LO  = 2'd3
	} phase_t;

	// One datagram byte.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	// One validation result.
	typedef struct packed {
		logic [2:0]       status;
		logic [15:0]      message_type;
		logic [15:0]      declared_length;
		logic [4:0]       attr_total;
		logic             found;
		logic [POS_W-1:0] found_offset;
	} result_item_t;

endpackage

[rtl/stunmv_in_stage.sv]
// ----------------------------------------------------------------------------
// STUN validator input stage
// Registers one incoming byte item and holds it until the parser takes it.
// ----------------------------------------------------------------------------
module stunmv_in_stage (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   byte_valid,
	output logic                   byte_ready,
	input  stunmv_pkg::byte_item_t byte_item,
	input  logic                   advance,
	output logic                   valid_s1,
	output stunmv_pkg::byte_item_t item_s1
);
	import stunmv_pkg::*;

	// The stage can take a new item when empty or when its item leaves now.
	assign byte_ready = !valid_s1 || advance;

	// Valid flag of the stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			item_s1 <= byte_item;
		end
	end

endmodule

[rtl/stunmv_parser.sv]
// ----------------------------------------------------------------------------
// STUN validator parser
// Holds per-datagram state, walks header and attributes one byte per cycle
// (a last byte waits for a free result slot), forms the result on that byte.
// ----------------------------------------------------------------------------
module stunmv_parser (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	input  logic [15:0]              cfg_data,
	input  logic                     valid_s1,
	input  stunmv_pkg::byte_item_t   item_s1,
	output logic                     advance,
	input  logic                     res_free,
	output logic                     res_load,
	output stunmv_pkg::result_item_t res_item
);
	import stunmv_pkg::*;

	// Configured attribute type.
	logic [15:0]           wanted_q;

	// Per-datagram state and its next value.
	logic [POS_W-1:0]      pos_q, pos_n;
	logic [15:0]           htype_q, htype_n;
	logic [15:0]           hlen_q, hlen_n;
	logic [15:0]           body_q, body_n;
	phase_t                phase_q, phase_n;
	logic [15:0]           atype_q, atype_n;
	logic [7:0]            alen_hi_q, alen_hi_n;
	logic [15:0]           vleft_q, vleft_n;
	logic [ATTR_CNT_W-1:0] acc_q, acc_n;
	status_t               err_q, err_n;
	logic                  match_q, match_n;
	logic [POS_W-1:0]      moff_q, moff_n;

	logic [7:0]            b;
	logic [15:0]           alen;
	logic [POS_W-1:0]      body_got;
	status_t               status;
	logic                  hdr_err;

	// Message types accepted in the header.
	function automatic logic type_known(input logic [15:0] t);
		return (t == 16'h0001) || (t == 16'h0101) || (t == 16'h0111) ||
		       (t == 16'h0002) || (t == 16'h0102) || (t == 16'h0112);
	endfunction

	// A byte moves on unless it closes a datagram and the result slot is busy.
	assign advance  = valid_s1 && (!item_s1.last_byte || res_free);
	assign res_load = advance && item_s1.last_byte;

	assign b    = item_s1.data_byte;
	assign alen = {alen_hi_q, b};

	// Next state for one byte: header capture, then the attribute walk.
	always_comb begin
		htype_n   = htype_q;
		hlen_n    = hlen_q;
		body_n    = body_q;
		phase_n   = phase_q;
		atype_n   = atype_q;
		alen_hi_n = alen_hi_q;
		vleft_n   = vleft_q;
		acc_n     = acc_q;
		err_n     = err_q;
		match_n   = match_q;
		moff_n    = moff_q;
		if (pos_q == POS_W'(0)) begin
			htype_n = {b, htype_q[7:0]};
		end else if (pos_q == POS_W'(1)) begin
			htype_n = {htype_q[15:8], b};
		end else if (pos_q == POS_W'(2)) begin
			hlen_n = {b, hlen_q[7:0]};
		end else if (pos_q == POS_W'(3)) begin
			hlen_n = {hlen_q[15:8], b};
			body_n = {hlen_q[15:8], b};
		end else if (pos_q >= POS_W'(HDR_BYTES) && body_q != 16'd0 && err_q == ST_OK) begin
			if (vleft_q != 16'd0) begin
				vleft_n = vleft_q - 16'd1;
				body_n  = body_q - 16'd1;
			end else begin
				unique case (phase_q)
					PH_TYPE_HI: begin
						if (acc_q >= ATTR_CNT_W'(MAX_ATTRS)) begin
							err_n = ST_TOO_MANY;
						end else if (body_q < 16'd4) begin
							err_n = ST_ATTR_OVERRUN;
						end else begin
							atype_n = {b, 8'h00};
							phase_n = PH_TYPE_LO;
							body_n  = body_q - 16'd1;
						end
					end
					PH_TYPE_LO: begin
						atype_n = {atype_q[15:8], b};
						phase_n = PH_LEN_HI;
						body_n  = body_q - 16'd1;
					end
					PH_LEN_HI: begin
						alen_hi_n = b;
						phase_n   = PH_LEN_LO;
						body_n    = body_q - 16'd1;
					end
					PH_LEN_LO: begin
						phase_n = PH_TYPE_HI;
						// The value must fit in what is left after this byte.
						if (alen >= body_q) begin
							err_n = ST_ATTR_OVERRUN;
						end else if (atype_q > 16'(ATTR_TYPE_MAX)) begin
							err_n = ST_BAD_ATTR_TYPE;
						end else begin
							acc_n   = acc_q + ATTR_CNT_W'(1);
							vleft_n = alen;
							body_n  = body_q - 16'd1;
							if (!match_q && atype_q == wanted_q) begin
								match_n = 1'b1;
								moff_n  = pos_q - POS_W'(3);
							end
						end
					end
					default: begin
						phase_n = PH_TYPE_HI;
					end
				endcase
			end
		end
	end

	// Byte position saturates at its maximum.
	assign pos_n = (pos_q == {POS_W{1'b1}}) ? pos_q : pos_q + POS_W'(1);

	// Result status in priority order, taken after this byte's update.
	assign body_got = pos_n - POS_W'(HDR_BYTES);
	always_comb begin
		priority if (pos_n < POS_W'(HDR_BYTES)) begin
			status = ST_SHORT;
		end else if (!type_known(htype_n)) begin
			status = ST_UNKNOWN_TYPE;
		end else if (body_got != {1'b0, hlen_n}) begin
			status = ST_LEN_MISMATCH;
		end else begin
			status = err_n;
		end
	end

	// Header errors report no attribute details.
	assign hdr_err = (status == ST_SHORT) || (status == ST_UNKNOWN_TYPE) ||
	                 (status == ST_LEN_MISMATCH);

	always_comb begin
		res_item.status          = status;
		res_item.message_type    = htype_n;
		res_item.declared_length = hlen_n;
		res_item.attr_total      = hdr_err ? 5'd0 : 5'(acc_n);
		res_item.found           = !hdr_err && match_n;
		res_item.found_offset    = (!hdr_err && match_n) ? moff_n : '0;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_q <= 16'd1;
		end else if (cfg_valid) begin
			wanted_q <= cfg_data;
		end
	end

	// Datagram state: updated per byte, cleared after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			htype_q   <= '0;
			hlen_q    <= '0;
			body_q    <= '0;
			phase_q   <= PH_TYPE_HI;
			atype_q   <= '0;
			alen_hi_q <= '0;
			vleft_q   <= '0;
			acc_q     <= '0;
			err_q     <= ST_OK;
			match_q   <= 1'b0;
			moff_q    <= '0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				pos_q     <= '0;
				htype_q   <= '0;
				hlen_q    <= '0;
				body_q    <= '0;
				phase_q   <= PH_TYPE_HI;
				atype_q   <= '0;
				alen_hi_q <= '0;
				vleft_q   <= '0;
				acc_q     <= '0;
				err_q     <= ST_OK;
				match_q   <= 1'b0;
				moff_q    <= '0;
			end else begin
				pos_q     <= pos_n;
				htype_q   <= htype_n;
				hlen_q    <= hlen_n;
				body_q    <= body_n;
				phase_q   <= phase_n;
				atype_q   <= atype_n;
				alen_hi_q <= alen_hi_n;
				vleft_q   <= vleft_n;
				acc_q     <= acc_n;
				err_q     <= err_n;
				match_q   <= match_n;
				moff_q    <= moff_n;
			end
		end
	end

endmodule

[rtl/stunmv_out_stage.sv]
// ----------------------------------------------------------------------------
// STUN validator result register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module stunmv_out_stage (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     res_load,
	output logic                     res_free,
	input  stunmv_pkg::result_item_t res_item,
	output logic                     result_valid,
	input  logic                     result_ready,
	output stunmv_pkg::result_item_t result_item
);
	import stunmv_pkg::*;

	// The slot can be refilled when empty or when its item is taken now.
	assign res_free = !result_valid || result_ready;

	// Valid flag of the result slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (res_free) begin
			result_valid <= res_load;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			result_item <= res_item;
		end
	end

endmodule

[rtl/stun_message_validator.sv]
// Path: a byte item is captured in the input register and parsed there; on
// the last byte the result item is loaded into the result register.
// Throughput: one byte item per cycle, limited only by the one-entry result
// register when a datagram's last byte meets a result not yet taken.
// Reset: arst_n clears the valid flags and the datagram state at once and
// sets the wanted attribute type (wanted_q in the parser) to 1.
// ----------------------------------------------------------------------------
// STUN message validator
// Checks a STUN datagram byte by byte and reports one result per datagram.
// ----------------------------------------------------------------------------
module stun_message_validator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [15:0]              cfg_data,
	input  logic                     byte_valid,
	output logic                     byte_ready,
	input  stunmv_pkg::byte_item_t   byte_item,
	output logic                     result_valid,
	input  logic                     result_ready,
	output stunmv_pkg::result_item_t result_item
);
	import stunmv_pkg::*;

	logic         valid_s1;
	byte_item_t   item_s1;
	logic         advance;
	logic         res_load;
	logic         res_free;
	result_item_t res_item;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	// Input register.
	stunmv_in_stage u_in (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	// Header and attribute walk.
	stunmv_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.valid_s1  (valid_s1),
		.item_s1   (item_s1),
		.advance   (advance),
		.res_free  (res_free),
		.res_load  (res_load),
		.res_item  (res_item)
	);

	// Result register.
	stunmv_out_stage u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.res_load     (res_load),
		.res_free     (res_free),
		.res_item     (res_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

endmodule

[rtl/stunmv_checker.sv]
// ----------------------------------------------------------------------------
// STUN validator port checker
// Watches the validator's ports for result consistency and a held result.
// ----------------------------------------------------------------------------
`include "stun_message_validator_defines.svh"

module stunmv_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     result_valid,
	input logic                     result_ready,
	input stunmv_pkg::result_item_t result_item
);
	import stunmv_pkg::*;

	logic hdr_err;

	// Header-level failures carry no attribute details.
	assign hdr_err = (result_item.status == ST_SHORT) ||
	                 (result_item.status == ST_UNKNOWN_TYPE) ||
	                 (result_item.status == ST_LEN_MISMATCH);

	`STUNMV_ASSERT_NOW(a_hdr_err_clean, clk, arst_n, result_valid && hdr_err, result_item.attr_total == 5'd0 && !result_item.found && result_item.found_offset == '0, "Header error result carries attribute details")

	`STUNMV_ASSERT_NOW(a_offset_needs_match, clk, arst_n, result_valid && !result_item.found, result_item.found_offset == '0, "Offset reported without a match")

	`STUNMV_ASSERT_NOW(a_match_past_header, clk, arst_n, result_valid && result_item.found, result_item.found_offset >= 17'd20 && result_item.attr_total != 5'd0, "Match outside the body or without an accepted attribute")

	`STUNMV_ASSERT_NEXT(a_result_held, clk, arst_n, result_valid && !result_ready, result_valid && $stable(result_item), "Stalled result item changed or dropped")

endmodule

bind stun_message_validator stunmv_checker u_stunmv_checker (.*);

[test/stun_message_validator_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STUN message validator testbench
// Feeds whole datagrams byte by byte, tracks the parse state alongside the
// block and compares each result item with the status, header fields,
// attribute count and match position worked out here.
// ----------------------------------------------------------------------------
module stun_message_validator_test;
	import stunmv_pkg::*;

	// STUN message types that the block recognizes.
	localparam logic [15:0] MT_BIND_REQ  = 16'h0001;
	localparam logic [15:0] MT_BIND_RESP = 16'h0101;
	localparam logic [15:0] MT_BIND_ERR  = 16'h0111;
	localparam logic [15:0] MT_SS_REQ    = 16'h0002;
	localparam logic [15:0] MT_SS_RESP   = 16'h0102;
	localparam logic [15:0] MT_SS_ERR    = 16'h0112;

	// A few attribute types used by the directed datagrams.
	localparam logic [15:0] AT_MAPPED_ADDRESS = 16'd1;
	localparam logic [15:0] AT_CHANGE_REQUEST = 16'd3;
	localparam logic [15:0] AT_USERNAME       = 16'd6;
	localparam logic [15:0] AT_REFLECTED_FROM = 16'd11;

	localparam int LONG_HOLD  = 300;
	localparam int TAIL_WAIT  = 8;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = '0;
	logic         byte_valid = 1'b0;
	logic         byte_ready;
	byte_item_t   byte_item = '0;
	logic         result_valid;
	logic         result_ready = 1'b0;
	result_item_t result_item;

	// Parse state kept alongside the block.
	logic [POS_W-1:0] rx_pos;
	logic [15:0]      hdr_type_q;
	logic [15:0]      hdr_len_q;
	logic [15:0]      body_left;
	phase_t           attr_phase;
	logic [15:0]      attr_type_acc;
	logic [15:0]      attr_len_acc;
	logic [15:0]      value_left;
	logic [4:0]       attrs_ok;
	status_t          walk_status;
	logic             match_hit;
	logic [POS_W-1:0] match_pos;
	logic [15:0]      want_type = 16'd1;

	result_item_t verdicts_due[$];
	logic [7:0]   dg[$];

	int errors = 0;
	int rx_mode = 0;
	bit tx_gaps = 1'b0;
	int burst_left = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int rx_step = 0;
	logic [15:0] rx_pattern = 16'b1100_1110_0101_1000;

	stun_message_validator i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.byte_valid   (byte_valid),
		.byte_ready   (byte_ready),
		.byte_item    (byte_item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_item  (result_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#10_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// Per-datagram state returns to zero after reset and after each last byte.
	function automatic void clear_datagram_state();
		rx_pos = '0;
		hdr_type_q = '0;
		hdr_len_q = '0;
		body_left = '0;
		attr_phase = PH_TYPE_HI;
		attr_type_acc = '0;
		attr_len_acc = '0;
		value_left = '0;
		attrs_ok = '0;
		walk_status = ST_OK;
		match_hit = 1'b0;
		match_pos = '0;
	endfunction

	// Advances the parse state by one accepted byte; returns 1 with the
	// expected result item when the byte closes a datagram.
	function automatic bit track_datagram_byte(input byte_item_t it,
			output result_item_t res);
		logic [7:0] b;
		int         total;
		status_t    st;
		b = it.data_byte;
		res = '0;

		// Header capture, then the attribute walk inside the declared body.
		if (rx_pos == 0) begin
			hdr_type_q[15:8] = b;
		end else if (rx_pos == 1) begin
			hdr_type_q[7:0] = b;
		end else if (rx_pos == 2) begin
			hdr_len_q[15:8] = b;
		end else if (rx_pos == 3) begin
			hdr_len_q[7:0] = b;
			body_left = {hdr_len_q[15:8], b};
		end else if (rx_pos >= HDR_BYTES && body_left != 0 && walk_status == ST_OK) begin
			if (value_left != 0) begin
				value_left--;
				body_left--;
			end else begin
				case (attr_phase)
					PH_TYPE_HI: begin
						if (attrs_ok >= MAX_ATTRS) begin
							walk_status = ST_TOO_MANY;
						end else if (body_left < 4) begin
							walk_status = ST_ATTR_OVERRUN;
						end else begin
							attr_type_acc = {b, 8'h00};
							attr_phase = PH_TYPE_LO;
							body_left--;
						end
					end
					PH_TYPE_LO: begin
						attr_type_acc[7:0] = b;
						attr_phase = PH_LEN_HI;
						body_left--;
					end
					PH_LEN_HI: begin
						attr_len_acc = {b, 8'h00};
						attr_phase = PH_LEN_LO;
						body_left--;
					end
					default: begin
						attr_len_acc[7:0] = b;
						attr_phase = PH_TYPE_HI;
						if (int'(attr_len_acc) + 4 > int'(body_left) + 3) begin
							walk_status = ST_ATTR_OVERRUN;
						end else if (attr_type_acc > ATTR_TYPE_MAX) begin
							walk_status = ST_BAD_ATTR_TYPE;
						end else begin
							attrs_ok++;
							if (!match_hit && attr_type_acc == want_type) begin
								match_hit = 1'b1;
								match_pos = rx_pos - POS_W'(3);
							end
							value_left = attr_len_acc;
							body_left--;
						end
					end
				endcase
			end
		end

		if (rx_pos != {POS_W{1'b1}})
			rx_pos++;
		if (!it.last_byte)
			return 1'b0;

		// Header errors take priority over anything the walk found.
		total = int'(rx_pos);
		if (total < HDR_BYTES)
			st = ST_SHORT;
		else if (!(hdr_type_q inside {MT_BIND_REQ, MT_BIND_RESP, MT_BIND_ERR,
				MT_SS_REQ, MT_SS_RESP, MT_SS_ERR}))
			st = ST_UNKNOWN_TYPE;
		else if (total - HDR_BYTES != int'(hdr_len_q))
			st = ST_LEN_MISMATCH;
		else
			st = walk_status;
		res.status = st;
		res.message_type = hdr_type_q;
		res.declared_length = hdr_len_q;
		if (!(st inside {ST_SHORT, ST_UNKNOWN_TYPE, ST_LEN_MISMATCH})) begin
			res.attr_total = attrs_ok;
			res.found = match_hit;
			res.found_offset = match_hit ? match_pos : '0;
		end
		clear_datagram_state();
		return 1'b1;
	endfunction

	// Receiver: never stalls, stalls at random or on a fixed pattern by mode,
	// or holds off entirely for a long stretch when asked.
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served = holds_asked;
			hold_left = LONG_HOLD;
		end
		rx_step++;
		if (hold_left > 0) begin
			hold_left--;
			result_ready = 1'b0;
		end else begin
			case (rx_mode)
				0: result_ready = 1'b1;
				1: result_ready = ($urandom_range(0, 3) != 0);
				2: result_ready = rx_pattern[rx_step % 16];
				default: result_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Result checker: every accepted result item against the oldest verdict.
	always @(posedge clk) begin
		result_item_t exp_res;
		if (arst_n && result_valid && result_ready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result item: actual %h", $time, result_item);
				errors++;
			end else begin
				exp_res = verdicts_due.pop_front();
				if (result_item !== exp_res) begin
					$display("%0t: result mismatch: expected %h, actual %h", $time,
						exp_res, result_item);
					errors++;
				end
			end
		end
	end

	// Sends one byte item, with bursty gaps when enabled.
	task automatic send_byte(input logic [7:0] d, input logic l);
		int gap;
		result_item_t res;
		if (tx_gaps) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 7);
				repeat (gap) begin
					@(negedge clk);
					byte_valid = 1'b0;
				end
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		@(negedge clk);
		byte_valid = 1'b1;
		byte_item.data_byte = d;
		byte_item.last_byte = l;
		do @(posedge clk); while (!byte_ready);
		if (track_datagram_byte(byte_item, res))
			verdicts_due.push_back(res);
	endtask

	task automatic send_dgram();
		for (int i = 0; i < dg.size(); i++)
			send_byte(dg[i], i == dg.size() - 1);
	endtask

	// Waits until every result has come and the block has settled.
	task automatic wait_quiet();
		@(negedge clk);
		byte_valid = 1'b0;
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_wanted(input logic [15:0] v);
		wait_quiet();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		want_type = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Datagram builders: header with random transaction id, attributes with
	// random values, and a length field fixed to the body actually built.
	function automatic void dg_start(input logic [15:0] mtype);
		dg.delete();
		dg.push_back(mtype[15:8]);
		dg.push_back(mtype[7:0]);
		dg.push_back(8'h00);
		dg.push_back(8'h00);
		repeat (16) dg.push_back(8'($urandom));
	endfunction

	function automatic void dg_fill(input int n);
		repeat (n) dg.push_back(8'($urandom));
	endfunction

	function automatic void dg_attr(input logic [15:0] atype, input logic [15:0] alen);
		dg.push_back(atype[15:8]);
		dg.push_back(atype[7:0]);
		dg.push_back(alen[15:8]);
		dg.push_back(alen[7:0]);
		dg_fill(alen);
	endfunction

	function automatic void dg_set_len(input logic [15:0] len);
		dg[2] = len[15:8];
		dg[3] = len[7:0];
	endfunction

	function automatic void dg_seal();
		dg_set_len(16'(dg.size() - HDR_BYTES));
	endfunction

	function automatic logic [15:0] known_type(input int k);
		case (k)
			0: return MT_BIND_REQ;
			1: return MT_BIND_RESP;
			2: return MT_BIND_ERR;
			3: return MT_SS_REQ;
			4: return MT_SS_RESP;
			default: return MT_SS_ERR;
		endcase
	endfunction

	// Match on the type selected at reset, with extreme data bytes in values.
	task automatic test_default_match();
		tx_gaps = 1'b1;
		rx_mode = 1;
		dg_start(MT_BIND_REQ);
		dg_attr(AT_MAPPED_ADDRESS, 16'd8);
		dg_attr(AT_CHANGE_REQUEST, 16'd4);
		dg[24] = 8'h00;
		dg[25] = 8'hFF;
		dg_seal();
		send_dgram();
	endtask

	// Every recognized message type but MT_BIND_REQ, one with an empty body.
	task automatic test_message_types();
		for (int k = 1; k < 6; k++) begin
			dg_start(known_type(k));
			if (k != 3) begin
				dg_attr(16'(k), 16'(k * 2));
				dg_attr(AT_MAPPED_ADDRESS, 16'd0);
			end
			dg_seal();
			send_dgram();
		end
	endtask

	// Datagrams ending inside the header.
	task automatic test_short();
		dg.delete();
		dg.push_back(8'hFF);
		send_dgram();
		dg_start(MT_BIND_REQ);
		dg = dg[0:2];
		send_dgram();
		dg_start(MT_SS_REQ);
		dg.pop_back();
		send_dgram();
	endtask

	// Unknown types and declared lengths that disagree with the bytes sent.
	task automatic test_header_errors();
		dg_start(16'h0000);
		dg_attr(AT_MAPPED_ADDRESS, 16'd4);
		dg_seal();
		send_dgram();
		dg_start(16'hFFFF);
		dg_seal();
		send_dgram();
		dg_start(MT_BIND_RESP);
		dg_attr(AT_MAPPED_ADDRESS, 16'd4);
		dg_set_len(16'd12);
		send_dgram();
		// Bytes past the declared body are not walked.
		dg_start(MT_BIND_RESP);
		dg_attr(AT_MAPPED_ADDRESS, 16'd4);
		dg_seal();
		dg_fill(6);
		send_dgram();
	endtask

	// Overruns, bad types, and an error after a match.
	task automatic test_attr_errors();
		// Attribute header cut off with two body bytes left.
		dg_start(MT_BIND_REQ);
		dg_attr(AT_USERNAME, 16'd4);
		dg_fill(2);
		dg_seal();
		send_dgram();
		// Attribute length reaching past the body.
		dg_start(MT_BIND_REQ);
		dg_attr(AT_MAPPED_ADDRESS, 16'd4);
		dg_attr(AT_USERNAME, 16'd8);
		dg = dg[0:dg.size() - 2];
		dg_seal();
		send_dgram();
		// Type just above the limit after a matching attribute.
		dg_start(MT_BIND_ERR);
		dg_attr(AT_MAPPED_ADDRESS, 16'd4);
		dg_attr(16'(ATTR_TYPE_MAX + 1), 16'd0);
		dg_seal();
		send_dgram();
		// Largest type, and the largest legal type accepted.
		dg_start(MT_SS_RESP);
		dg_attr(AT_REFLECTED_FROM, 16'd1);
		dg_attr(16'hFFFF, 16'd2);
		dg_seal();
		send_dgram();
	endtask

	// Exactly the attribute limit, then one beyond it.
	task automatic test_attr_limit();
		for (int extra = 0; extra < 2; extra++) begin
			dg_start(MT_BIND_RESP);
			for (int i = 0; i < MAX_ATTRS + extra; i++)
				dg_attr(16'(i % (ATTR_TYPE_MAX + 1)), 16'(i % 3));
			dg_seal();
			send_dgram();
		end
	endtask

	// Register extremes: type zero, the top type absent then present, type 11.
	task automatic test_config_extremes();
		write_wanted(16'h0000);
		dg_start(MT_BIND_REQ);
		dg_attr(AT_MAPPED_ADDRESS, 16'd3);
		dg_attr(16'h0000, 16'd5);
		dg_attr(16'h0000, 16'd0);
		dg_seal();
		send_dgram();
		write_wanted(16'hFFFF);
		dg_start(MT_BIND_REQ);
		dg_attr(AT_MAPPED_ADDRESS, 16'd4);
		dg_seal();
		send_dgram();
		dg_start(MT_BIND_REQ);
		dg_attr(16'hFFFF, 16'd0);
		dg_seal();
		send_dgram();
		write_wanted(AT_REFLECTED_FROM);
		dg_start(MT_SS_ERR);
		dg_attr(AT_USERNAME, 16'd4);
		dg_attr(AT_REFLECTED_FROM, 16'd2);
		dg_seal();
		send_dgram();
	endtask

	// Receiver holds off while header-only datagrams keep coming, so the
	// result register fills and the byte input stalls.
	task automatic test_pressure();
		wait_quiet();
		tx_gaps = 1'b0;
		holds_asked++;
		repeat (8) begin
			dg_start(known_type($urandom_range(0, 5)));
			dg_seal();
			send_dgram();
		end
		tx_gaps = 1'b1;
	endtask

	// Mostly well-formed datagrams with random content, plus mutated ones,
	// noise and datagrams crowded with attributes, over several settings.
	task automatic test_random();
		int bytes_sent;
		int kind;
		int n;
		int pick;
		logic [15:0] at;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: write_wanted(16'($urandom_range(0, ATTR_TYPE_MAX)));
				1: write_wanted(16'h0000);
				2: write_wanted(16'(ATTR_TYPE_MAX));
				default: write_wanted(16'($urandom_range(1, 3)));
			endcase
			rx_mode = phase;
			tx_gaps = (phase != 1);
			bytes_sent = 0;
			while (bytes_sent < 30) begin
				kind = $urandom_range(0, 99);
				if (kind < 80) begin
					if ($urandom_range(0, 19) == 0)
						dg_start(16'($urandom));
					else
						dg_start(known_type($urandom_range(0, 5)));
					n = (kind < 70) ? $urandom_range(0, 6) : $urandom_range(13, 18);
					for (int i = 0; i < n; i++) begin
						if ($urandom_range(0, 15) == 0)
							at = 16'($urandom_range(ATTR_TYPE_MAX + 1, 65535));
						else
							at = 16'($urandom_range(0, ATTR_TYPE_MAX));
						dg_attr(at, 16'((kind < 70) ? $urandom_range(0, 12) :
							$urandom_range(0, 2)));
					end
					dg_seal();
					// Some datagrams get broken after sealing.
					if ($urandom_range(0, 7) == 0) begin
						pick = $urandom_range(0, 2);
						if (pick == 0)
							dg[$urandom_range(0, dg.size() - 1)] = 8'($urandom);
						else if (pick == 1 && dg.size() > 1)
							dg.pop_back();
						else
							dg_fill($urandom_range(1, 5));
					end
				end else begin
					dg.delete();
					dg_fill($urandom_range(1, 40));
				end
				send_dgram();
				bytes_sent += dg.size();
			end
		end
	endtask

	initial begin
		clear_datagram_state();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_default_match();
		test_message_types();
		test_short();
		test_header_errors();
		test_attr_errors();
		test_attr_limit();
		test_config_extremes();
		test_pressure();
		test_random();

		wait_quiet();
		repeat (TAIL_WAIT) @(posedge clk);
		if (verdicts_due.size() != 0) begin
			$display("%0t: %0d expected result items never arrived", $time,
				verdicts_due.size());
			errors++;
		end
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
